### design/vmt_pkg.sv
package vmt_pkg;

    localparam int NumRegs   = 8;
    localparam int RegIdxW   = $clog2(NumRegs);
    localparam int ByteOffW  = 3;
    localparam int AddrW     = RegIdxW + ByteOffW;
    localparam int CfgW      = 64;
    localparam int QW        = 32;
    localparam int FracBits  = 16;
    localparam int ProdW     = 2 * QW;
    localparam int PairW     = ProdW + 1;
    localparam int SumW      = ProdW + 2;
    localparam int Dim       = 4;

    typedef logic signed [QW-1:0]    t_q16;
    typedef logic signed [ProdW-1:0] t_prod;
    typedef logic signed [PairW-1:0] t_pair;
    typedef logic signed [SumW-1:0]  t_sum;
    typedef logic [CfgW-1:0]         t_cfg_word;

    localparam t_q16 QMax = 32'sh7FFF_FFFF;
    localparam t_q16 QMin = 32'sh8000_0000;

    // Reset image of the coefficient registers: the identity matrix.
    localparam t_cfg_word CfgReset [NumRegs] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

endpackage

### design/vertex_matrix_transform.sv
// Transforms one homogeneous Q16.16 vertex (x, y, z, w) by a 4x4 matrix, row-vector
// convention: out[c] = floor(sum over r of in[r] * m[r][c] / 2^16), saturated to 32 bits,
// with o_overflow set when any component saturates. A vertex is accepted on every clock
// while the output side takes results; each one passes through four register stages
// (products, pair sums, full sums, shift and saturation) before it leaves. Back
// pressure on the output stalls the stages in order, so nothing is lost or repeated. The
// sixteen coefficients live in eight 64-bit registers at byte address 8*i, two Q16.16
// values each (column 2k in bits 31:0, column 2k+1 in bits 63:32), reset to identity.
// Coefficients should only be rewritten while no vertex is in flight.
module vertex_matrix_transform (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [31:0]            i_in_x,
    input  logic signed [31:0]            i_in_y,
    input  logic signed [31:0]            i_in_z,
    input  logic signed [31:0]            i_in_w,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [31:0]            o_out_x,
    output logic signed [31:0]            o_out_y,
    output logic signed [31:0]            o_out_z,
    output logic signed [31:0]            o_out_w,
    output logic                          o_overflow,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vmt_pkg::AddrW-1:0]     paddr,
    input  logic [vmt_pkg::CfgW-1:0]      pwdata,
    output logic [vmt_pkg::CfgW-1:0]      prdata,
    output logic                          pready
);

    vmt_pkg::t_cfg_word r_cfg [vmt_pkg::NumRegs];

    vmt_pkg::t_q16 in_v [vmt_pkg::Dim];
    vmt_pkg::t_q16 coef [vmt_pkg::Dim][vmt_pkg::Dim];

    vmt_pkg::t_prod r_prod [vmt_pkg::Dim][vmt_pkg::Dim];
    vmt_pkg::t_pair r_pair [vmt_pkg::Dim][2];
    vmt_pkg::t_sum  r_sum  [vmt_pkg::Dim];
    vmt_pkg::t_q16  r_out  [vmt_pkg::Dim];
    vmt_pkg::t_q16  n_out  [vmt_pkg::Dim];
    logic           r_ovf;
    logic           n_ovf;

    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;
    logic cfg_wr;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = r_cfg[paddr[vmt_pkg::AddrW-1:vmt_pkg::ByteOffW]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < vmt_pkg::NumRegs; i++) begin
                r_cfg[i] <= vmt_pkg::CfgReset[i];
            end
        end else if (cfg_wr) begin
            r_cfg[paddr[vmt_pkg::AddrW-1:vmt_pkg::ByteOffW]] <= pwdata;
        end
    end

    // Coefficient m[r][c] sits in register 2r + c/2, upper half for odd columns.
    for (genvar gr = 0; gr < vmt_pkg::Dim; gr++) begin : g_row
        for (genvar gc = 0; gc < vmt_pkg::Dim; gc++) begin : g_col
            assign coef[gr][gc] =
                r_cfg[2*gr + gc/2][(gc%2)*vmt_pkg::QW +: vmt_pkg::QW];
        end
    end

    assign in_v[0] = i_in_x;
    assign in_v[1] = i_in_y;
    assign in_v[2] = i_in_z;
    assign in_v[3] = i_in_w;

    // ---------------- stage enables ----------------
    assign en4     = !r_v4 || i_ready;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // ---------------- stage 1: sixteen products ----------------
    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            for (int r = 0; r < vmt_pkg::Dim; r++) begin
                for (int c = 0; c < vmt_pkg::Dim; c++) begin
                    r_prod[r][c] <= vmt_pkg::t_prod'(in_v[r]) * vmt_pkg::t_prod'(coef[r][c]);
                end
            end
        end
    end

    // ---------------- stage 2: pair sums ----------------
    always_ff @(posedge i_clk) begin
        if (en2 && r_v1) begin
            for (int c = 0; c < vmt_pkg::Dim; c++) begin
                r_pair[c][0] <= vmt_pkg::t_pair'(r_prod[0][c])
                              + vmt_pkg::t_pair'(r_prod[1][c]);
                r_pair[c][1] <= vmt_pkg::t_pair'(r_prod[2][c])
                              + vmt_pkg::t_pair'(r_prod[3][c]);
            end
        end
    end

    // ---------------- stage 3: full sums ----------------
    always_ff @(posedge i_clk) begin
        if (en3 && r_v2) begin
            for (int c = 0; c < vmt_pkg::Dim; c++) begin
                r_sum[c] <= vmt_pkg::t_sum'(r_pair[c][0]) + vmt_pkg::t_sum'(r_pair[c][1]);
            end
        end
    end

    // ---------------- stage 4: floor shift and saturation ----------------
    // The shifted value fits in 32 bits exactly when bits 65 down to 47 all agree.
    always_comb begin
        n_ovf = 1'b0;
        for (int c = 0; c < vmt_pkg::Dim; c++) begin
            if ((&r_sum[c][vmt_pkg::SumW-1:vmt_pkg::QW+vmt_pkg::FracBits-1]) ||
                !(|r_sum[c][vmt_pkg::SumW-1:vmt_pkg::QW+vmt_pkg::FracBits-1])) begin
                n_out[c] = r_sum[c][vmt_pkg::QW+vmt_pkg::FracBits-1:vmt_pkg::FracBits];
            end else begin
                n_out[c] = r_sum[c][vmt_pkg::SumW-1] ? vmt_pkg::QMin : vmt_pkg::QMax;
                n_ovf    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4 && r_v3) begin
            for (int c = 0; c < vmt_pkg::Dim; c++) begin
                r_out[c] <= n_out[c];
            end
            r_ovf <= n_ovf;
        end
    end

    assign o_valid    = r_v4;
    assign o_out_x    = r_out[0];
    assign o_out_y    = r_out[1];
    assign o_out_z    = r_out[2];
    assign o_out_w    = r_out[3];
    assign o_overflow = r_ovf;

    // ---------------- assertions ----------------
    a_ovf_means_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |->
            (o_out_x == vmt_pkg::QMax || o_out_x == vmt_pkg::QMin ||
             o_out_y == vmt_pkg::QMax || o_out_y == vmt_pkg::QMin ||
             o_out_z == vmt_pkg::QMax || o_out_z == vmt_pkg::QMin ||
             o_out_w == vmt_pkg::QMax || o_out_w == vmt_pkg::QMin))
        else $error("overflow flagged without a saturated component");

    a_stage3_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_v4 && !i_ready) |=> (r_v3 && $stable(r_sum[0]) && $stable(r_sum[3])))
        else $error("full sums changed while the output stage was stalled");

    a_empty_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> o_ready)
        else $error("empty product stage refused an input transfer");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && paddr[vmt_pkg::AddrW-1:vmt_pkg::ByteOffW] == '0) |=>
            (r_cfg[0] == $past(pwdata)))
        else $error("coefficient register write was lost");

endmodule
